@@ hdl/sfr_pkg.sv @@
// Shared types and constants of the stream find-and-replace unit.
package sfr_pkg;

	localparam int BYTE_W      = 8;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int LEN_FIELD_W = 4;
	localparam int TOTAL_W     = 32;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN_BYTES      = 2'd0,
		CFG_PATTERN_LENGTH     = 2'd1,
		CFG_REPLACEMENT_BYTES  = 2'd2,
		CFG_REPLACEMENT_LENGTH = 2'd3
	} cfg_index_t;

	// Per-cell control from the sequencer.
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage

@@ hdl/stream_find_replace_unit.sv @@
// Top level of the streaming find-and-replace unit.
//
// Input channel: text_byte and line_end move on a transaction when in_valid is
// high and in_stall is low. Each input transaction yields zero to eight result
// transactions of out_byte, run_last and replace_total, marked by out_valid and
// taken when out_stall is low. run_last flags the final result of one input byte.
// Configuration: cfg_index selects pattern_bytes, pattern_length,
// replacement_bytes or replacement_length; a write completes when cfg_valid and
// cfg_ready are both high. cfg_ready is always high; write only while idle.
// Writing pattern_length drops any held bytes.
// Timing: an input byte is taken in the idle state; the sequencer then emits its
// result bytes from SCAN, REPL or FLUSH, with an extra SCAN step that gives no
// result whenever the scan stops on a match or on a pattern prefix. The first
// result is registered from SCAN, from REPL after SCAN when the byte completes a
// match, or from FLUSH after SCAN when a held prefix ends a line.
// Output is paced by the single result register, at most one byte per cycle while out_stall is low.
// A stalled receiver holds the result register and the sequencer waits; the next
// input byte is still taken once the sequencer returns to idle.
// Reset clears all configuration, the held bytes and the replacement count.
module stream_find_replace_unit #(
	parameter int PATTERN_MAX     = 8,
	parameter int REPLACEMENT_MAX = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [sfr_pkg::BYTE_W-1:0]         text_byte,
	input  logic                               line_end,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [sfr_pkg::BYTE_W-1:0]         out_byte,
	output logic                               run_last,
	output logic [sfr_pkg::TOTAL_W-1:0]        replace_total,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sfr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import sfr_pkg::*;

	localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
	localparam int RLEN_W = $clog2(REPLACEMENT_MAX + 1);

	logic [PATTERN_MAX*BYTE_W-1:0]     pat_q;
	logic [LEN_W-1:0]                  pat_len_q;
	logic [REPLACEMENT_MAX*BYTE_W-1:0] repl_q;
	logic [RLEN_W-1:0]                 repl_len_q;
	logic                              cfg_write;
	logic                              len_clear;
	logic [LEN_FIELD_W-1:0]            len_field;

	cell_ctl_t [PATTERN_MAX-1:0]       cell_ctl;
	logic [BYTE_W-1:0]                 cell_bytes [PATTERN_MAX];
	logic [BYTE_W-1:0]                 cell_next  [PATTERN_MAX];
	logic [PATTERN_MAX-1:0]            eq_here;
	logic [PATTERN_MAX-1:0]            eq_prev;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign len_field = cfg_data[LEN_FIELD_W-1:0];
	assign len_clear = cfg_write && (cfg_index_t'(cfg_index) == CFG_PATTERN_LENGTH);

	// Lengths above PATTERN_MAX or REPLACEMENT_MAX are clamped when written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q      <= '0;
			pat_len_q  <= '0;
			repl_q     <= '0;
			repl_len_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index_t'(cfg_index))
				CFG_PATTERN_BYTES: begin
					pat_q <= cfg_data[PATTERN_MAX*BYTE_W-1:0];
				end
				CFG_PATTERN_LENGTH: begin
					pat_len_q <= (len_field > LEN_FIELD_W'(PATTERN_MAX)) ?
						LEN_W'(PATTERN_MAX) : len_field[LEN_W-1:0];
				end
				CFG_REPLACEMENT_BYTES: begin
					repl_q <= cfg_data[REPLACEMENT_MAX*BYTE_W-1:0];
				end
				CFG_REPLACEMENT_LENGTH: begin
					repl_len_q <= (len_field > LEN_FIELD_W'(REPLACEMENT_MAX)) ?
						RLEN_W'(REPLACEMENT_MAX) : len_field[RLEN_W-1:0];
				end
				default: begin
					pat_q <= pat_q;
				end
			endcase
		end
	end

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		localparam int PREV = (i == 0) ? 0 : i - 1;

		if (i == PATTERN_MAX - 1) begin : g_tail
			assign cell_next[i] = '0;
		end else begin : g_link
			assign cell_next[i] = cell_bytes[i+1];
		end

		sfr_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl[i]),
			.in_byte   (text_byte),
			.next_byte (cell_next[i]),
			.pat_here  (pat_q[i*BYTE_W +: BYTE_W]),
			.pat_prev  (pat_q[PREV*BYTE_W +: BYTE_W]),
			.cell_byte (cell_bytes[i]),
			.eq_here   (eq_here[i]),
			.eq_prev   (eq_prev[i])
		);
	end

	sfr_ctrl #(
		.PATTERN_MAX     (PATTERN_MAX),
		.REPLACEMENT_MAX (REPLACEMENT_MAX)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_line_end   (line_end),
		.in_stall      (in_stall),
		.len_clear     (len_clear),
		.pat_len       (pat_len_q),
		.repl_len      (repl_len_q),
		.repl_bytes    (repl_q),
		.front_byte    (cell_bytes[0]),
		.eq_here       (eq_here),
		.eq_prev       (eq_prev),
		.cell_ctl      (cell_ctl),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.run_last      (run_last),
		.replace_total (replace_total)
	);

endmodule

@@ hdl/sfr_cell.sv @@
// One cell of the holding chain: a text byte and its two pattern comparators.
module sfr_cell (
	input  logic                      clk,
	input  sfr_pkg::cell_ctl_t        ctl,
	input  logic [sfr_pkg::BYTE_W-1:0] in_byte,
	input  logic [sfr_pkg::BYTE_W-1:0] next_byte,
	input  logic [sfr_pkg::BYTE_W-1:0] pat_here,
	input  logic [sfr_pkg::BYTE_W-1:0] pat_prev,
	output logic [sfr_pkg::BYTE_W-1:0] cell_byte,
	output logic                      eq_here,
	output logic                      eq_prev
);
	import sfr_pkg::*;

	logic [BYTE_W-1:0] byte_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			byte_q <= in_byte;
		end else if (ctl.shift) begin
			byte_q <= next_byte;
		end
	end

	assign cell_byte = byte_q;
	assign eq_here   = (byte_q == pat_here);
	// Compare against the pattern one place back, as if the chain had shifted once.
	assign eq_prev   = (byte_q == pat_prev);

endmodule

@@ hdl/sfr_ctrl.sv @@
// Sequencer of the find-and-replace chain with the result register and counter.
module sfr_ctrl #(
	parameter int PATTERN_MAX     = 8,
	parameter int REPLACEMENT_MAX = 8
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	input  logic                                    in_line_end,
	output logic                                    in_stall,
	input  logic                                    len_clear,
	input  logic [$clog2(PATTERN_MAX+1)-1:0]        pat_len,
	input  logic [$clog2(REPLACEMENT_MAX+1)-1:0]    repl_len,
	input  logic [REPLACEMENT_MAX*sfr_pkg::BYTE_W-1:0] repl_bytes,
	input  logic [sfr_pkg::BYTE_W-1:0]              front_byte,
	input  logic [PATTERN_MAX-1:0]                  eq_here,
	input  logic [PATTERN_MAX-1:0]                  eq_prev,
	output sfr_pkg::cell_ctl_t [PATTERN_MAX-1:0]    cell_ctl,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [sfr_pkg::BYTE_W-1:0]              out_byte,
	output logic                                    run_last,
	output logic [sfr_pkg::TOTAL_W-1:0]             replace_total
);
	import sfr_pkg::*;

	localparam int CNT_W  = $clog2(PATTERN_MAX + 1);
	localparam int RLEN_W = $clog2(REPLACEMENT_MAX + 1);
	localparam int RIDX_W = (REPLACEMENT_MAX > 1) ? $clog2(REPLACEMENT_MAX) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_REPL,
		ST_FLUSH
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic                line_end_q;
	logic [RIDX_W-1:0]   idx_q;
	logic [TOTAL_W-1:0]  total_q;
	logic                out_valid_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic                run_last_q;
	logic [TOTAL_W-1:0]  out_total_q;

	logic                accept;
	logic                can_emit;
	logic                same;
	logic                full;
	logic                rest_prefix;
	logic                emit;
	logic                emit_last;
	logic [BYTE_W-1:0]   emit_byte;
	logic                shift;
	logic                repl_last;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign can_emit = !out_valid_q || !out_stall;
	assign repl_last = ((RLEN_W'(idx_q) + RLEN_W'(1)) == repl_len);

	// The front matches when each held byte within pat_len equals its pattern byte.
	always_comb begin
		same        = 1'b1;
		rest_prefix = 1'b1;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			if ((CNT_W'(i) < count_q) && (CNT_W'(i) < pat_len) && !eq_here[i]) begin
				same = 1'b0;
			end
			if ((i >= 1) && (CNT_W'(i) < count_q) && !eq_prev[i]) begin
				rest_prefix = 1'b0;
			end
		end
		full = same && (count_q >= pat_len);
	end

	always_comb begin
		emit      = 1'b0;
		emit_last = 1'b0;
		emit_byte = front_byte;
		shift     = 1'b0;
		case (state_q)
			ST_SCAN: begin
				if (pat_len == '0) begin
					emit      = can_emit;
					emit_last = 1'b1;
				end else if (!same) begin
					emit  = can_emit;
					shift = can_emit;
					// Last when nothing follows, or the rest is a prefix that stays held.
					emit_last = (count_q == CNT_W'(1)) || (!line_end_q && rest_prefix);
				end
			end
			ST_REPL: begin
				emit      = can_emit;
				emit_byte = repl_bytes[idx_q * BYTE_W +: BYTE_W];
				emit_last = repl_last;
			end
			ST_FLUSH: begin
				emit      = can_emit;
				shift     = can_emit;
				emit_last = (count_q == CNT_W'(1));
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			cell_ctl[i].load  = accept && (count_q == CNT_W'(i));
			cell_ctl[i].shift = shift;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			line_end_q  <= 1'b0;
			idx_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= emit_byte;
				run_last_q  <= emit_last;
				out_total_q <= total_q;
			end
			if (len_clear) begin
				count_q <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q    <= count_q + CNT_W'(1);
						line_end_q <= in_line_end;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (pat_len == '0) begin
						if (can_emit) begin
							count_q <= '0;
							state_q <= ST_IDLE;
						end
					end else if (full) begin
						if (total_q != '1) begin
							total_q <= total_q + TOTAL_W'(1);
						end
						count_q <= '0;
						idx_q   <= '0;
						state_q <= (repl_len == '0) ? ST_IDLE : ST_REPL;
					end else if (same) begin
						// A partial match is held, or flushed at the end of a line.
						state_q <= line_end_q ? ST_FLUSH : ST_IDLE;
					end else if (can_emit) begin
						count_q <= count_q - CNT_W'(1);
						if (count_q == CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_REPL: begin
					if (can_emit) begin
						idx_q <= idx_q + RIDX_W'(1);
						if (repl_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FLUSH: begin
					if (can_emit) begin
						count_q <= count_q - CNT_W'(1);
						if (count_q == CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign run_last      = run_last_q;
	assign replace_total = out_total_q;

endmodule

@@ hdl/sfr_checker.sv @@
// Port-level checks of the find-and-replace unit and their binding.
module sfr_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic [sfr_pkg::BYTE_W-1:0]     text_byte,
	input logic                           line_end,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [sfr_pkg::BYTE_W-1:0]     out_byte,
	input logic                           run_last,
	input logic [sfr_pkg::TOTAL_W-1:0]    replace_total,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sfr_pkg::*;

	logic out_take;
	logic unused_ok;

	assign out_take  = out_valid && !out_stall;
	assign unused_ok = ^{text_byte, line_end, cfg_valid, cfg_ready, cfg_index, cfg_data};

	// A result waiting on a stalled receiver stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_byte) && $stable(run_last)
			&& $stable(replace_total))
		else $error("stalled result changed");

	// The input always stalls in the cycle after a byte is taken.
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken on two successive cycles");

	// The replacement count never goes down between back-to-back results.
	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && $past(out_take) |-> replace_total >= $past(replace_total))
		else $error("replacement count decreased");

	// No result is offered in the cycle after reset is seen low at the clock.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid && (unused_ok || !unused_ok))
		else $error("result offered during reset");

endmodule

bind stream_find_replace_unit sfr_checker u_sfr_checker (.*);

@@ test/testbench.sv @@
// Self-checking testbench for the streaming find-and-replace unit.
`timescale 1ns / 100ps

module testbench;
	import sfr_pkg::*;

	localparam int          PATTERN_MAX   = 8;
	localparam int          HELD_MAX      = PATTERN_MAX - 1;
	localparam int          RESULT_MAX    = 8;
	localparam int          SETTLE_CYCLES = 14;
	localparam int          LONG_HOLD     = 400;
	localparam int unsigned CYCLE_LIMIT   = 1000000;

	typedef struct {
		logic [BYTE_W-1:0]  ch;
		logic               last;
		logic [TOTAL_W-1:0] total;
	} text_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [BYTE_W-1:0]     text_byte = '0;
	logic                  line_end = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [BYTE_W-1:0]     out_byte;
	logic                  run_last;
	logic [TOTAL_W-1:0]    replace_total;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_index_t            cfg_index = CFG_PATTERN_BYTES;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow copy of the block's settings and matching state.
	logic [CFG_DATA_W-1:0] pat_bytes = '0;
	int                    pat_len = 0;
	logic [CFG_DATA_W-1:0] rep_bytes = '0;
	int                    rep_len = 0;
	logic [BYTE_W-1:0]     held [0:HELD_MAX-1];
	int                    held_n = 0;
	logic [TOTAL_W-1:0]    repl_count = '0;

	text_result_t pending_text [$];
	int           fail_count = 0;
	int unsigned  cycle_count = 0;
	int unsigned  hold_requests = 0;
	bit           sender_calm = 1'b0;

	stream_find_replace_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.text_byte     (text_byte),
		.line_end      (line_end),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.run_last      (run_last),
		.replace_total (replace_total),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Works out the rewritten bytes caused by one input byte and queues them.
	function automatic void rewrite_byte(input logic [BYTE_W-1:0] b, input logic le);
		logic [BYTE_W-1:0] window [0:PATTERN_MAX];
		logic [BYTE_W-1:0] emitted [$];
		text_result_t      r;
		int                n, pos, avail, cmp, i;
		bit                same;
		if (pat_len == 0) begin
			emitted.push_back(b);
			held_n = 0;
		end else begin
			for (i = 0; i < held_n; i++)
				window[i] = held[i];
			window[held_n] = b;
			n = held_n + 1;
			pos = 0;
			while (pos < n) begin
				avail = n - pos;
				cmp = (avail < pat_len) ? avail : pat_len;
				same = 1'b1;
				for (i = 0; i < cmp; i++) begin
					if (window[pos + i] != pat_bytes[i*8 +: 8]) begin
						same = 1'b0;
						break;
					end
				end
				if (same) begin
					// A partial match at the tail stays held for the next byte, or is flushed at a line end.
					if (avail < pat_len)
						break;
					for (i = 0; i < rep_len; i++)
						if (emitted.size() < RESULT_MAX)
							emitted.push_back(rep_bytes[i*8 +: 8]);
					if (repl_count != '1)
						repl_count++;
					pos += pat_len;
				end else begin
					if (emitted.size() < RESULT_MAX)
						emitted.push_back(window[pos]);
					pos++;
				end
			end
			held_n = 0;
			while (pos < n) begin
				if (le) begin
					if (emitted.size() < RESULT_MAX)
						emitted.push_back(window[pos]);
				end else if (held_n < HELD_MAX) begin
					held[held_n] = window[pos];
					held_n++;
				end
				pos++;
			end
		end
		foreach (emitted[k]) begin
			r.ch = emitted[k];
			r.last = (k == emitted.size() - 1);
			r.total = repl_count;
			pending_text.push_back(r);
		end
	endfunction

	function automatic void apply_setting(input cfg_index_t idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_PATTERN_BYTES: pat_bytes = data;
			CFG_PATTERN_LENGTH: begin
				pat_len = (data[3:0] > PATTERN_MAX) ? PATTERN_MAX : int'(data[3:0]);
				held_n = 0;
			end
			CFG_REPLACEMENT_BYTES: rep_bytes = data;
			CFG_REPLACEMENT_LENGTH: begin
				rep_len = (data[3:0] > RESULT_MAX) ? RESULT_MAX : int'(data[3:0]);
			end
			default: ;
		endcase
	endfunction

	// Half the time no gap, often a short one, now and then a long one.
	function automatic int unsigned random_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic logic [BYTE_W-1:0] pick_text_byte();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return BYTE_W'(8'h61 + $urandom_range(0, 3));
		else if (r < 7)
			return pat_bytes[7:0];
		else
			return BYTE_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [CFG_DATA_W-1:0] random_pattern_word();
		logic [CFG_DATA_W-1:0] w;
		int unsigned           r;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			r = $urandom_range(0, 9);
			if (r < 6)
				w[i*8 +: 8] = BYTE_W'(8'h61 + $urandom_range(0, 3));
			else if (r == 6)
				w[i*8 +: 8] = 8'h00;
			else if (r == 7)
				w[i*8 +: 8] = 8'hFF;
			else
				w[i*8 +: 8] = BYTE_W'($urandom_range(0, 255));
		end
		return w;
	endfunction

	// Length field with random upper bits; the block only uses the low nibble.
	function automatic logic [CFG_DATA_W-1:0] random_length_word();
		logic [CFG_DATA_W-1:0] w;
		int unsigned           r;
		w = {$urandom, $urandom};
		r = $urandom_range(0, 19);
		if (r == 0)
			w[3:0] = 4'd0;
		else if (r == 1)
			w[3:0] = 4'($urandom_range(9, 15));
		else
			w[3:0] = 4'($urandom_range(1, 8));
		return w;
	endfunction

	function automatic logic pick_line_end();
		return ($urandom_range(0, 15) == 0);
	endfunction

	// Receiver: random stall gaps, calm stretches and requested long hold-offs.
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned stall_left = 0;
	int unsigned calm_left = 0;
	always @(posedge clk) begin
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = LONG_HOLD;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (calm_left != 0)
				calm_left--;
			else if ($urandom_range(0, 99) == 0)
				calm_left = $urandom_range(50, 200);
			else if ($urandom_range(0, 3) == 0)
				stall_left = random_gap();
		end
	end

	always @(posedge clk) begin
		text_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_text.size() == 0) begin
				$error("unexpected result transaction: out_byte %h", out_byte);
				fail_count++;
			end else begin
				want = pending_text.pop_front();
				if (out_byte !== want.ch) begin
					$error("out_byte: expected %h, actual %h", want.ch, out_byte);
					fail_count++;
				end
				if (run_last !== want.last) begin
					$error("run_last: expected %b, actual %b", want.last, run_last);
					fail_count++;
				end
				if (replace_total !== want.total) begin
					$error("replace_total: expected %0d, actual %0d", want.total,
						replace_total);
					fail_count++;
				end
			end
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic le);
		int unsigned gap;
		in_valid  <= 1'b1;
		text_byte <= b;
		line_end  <= le;
		do @(posedge clk); while (in_stall);
		rewrite_byte(b, le);
		gap = sender_calm ? 0 : random_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Waits for every expected result, then lets a byte that gives none finish.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_text.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_setting(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_setting(idx, data);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_rule(input logic [CFG_DATA_W-1:0] pb, input logic [CFG_DATA_W-1:0] pl,
			input logic [CFG_DATA_W-1:0] rb, input logic [CFG_DATA_W-1:0] rl);
		write_setting(CFG_PATTERN_BYTES, pb);
		write_setting(CFG_PATTERN_LENGTH, pl);
		write_setting(CFG_REPLACEMENT_BYTES, rb);
		write_setting(CFG_REPLACEMENT_LENGTH, rl);
	endtask

	// Well-formed occurrences, partial prefixes, near misses and loose bytes.
	task automatic send_mixed_text(input int count);
		int          sent, cut, flip, i;
		int unsigned kind;
		logic [BYTE_W-1:0] b;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(0, 9);
			if (kind < 4 && pat_len > 0) begin
				for (i = 0; i < pat_len; i++)
					send_byte(pat_bytes[i*8 +: 8], (i == pat_len - 1) && pick_line_end());
				sent += pat_len;
			end else if (kind < 6 && pat_len > 1) begin
				cut = $urandom_range(1, pat_len - 1);
				for (i = 0; i < cut; i++)
					send_byte(pat_bytes[i*8 +: 8], (i == cut - 1) && ($urandom_range(0, 2) == 0));
				sent += cut;
			end else if (kind < 7 && pat_len > 1) begin
				flip = $urandom_range(1, pat_len - 1);
				for (i = 0; i < pat_len; i++) begin
					b = pat_bytes[i*8 +: 8];
					if (i == flip)
						b = b ^ (8'h01 << $urandom_range(0, 7));
					send_byte(b, 1'b0);
				end
				sent += pat_len;
			end else begin
				send_byte(pick_text_byte(), pick_line_end());
				sent++;
			end
		end
	endtask

	// Registers are zero after reset, so bytes pass straight through.
	task automatic test_pass_through();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h5A, 1'b0);
	endtask

	task automatic test_match_and_flush();
		set_rule(64'h6261, 64'd2, 64'h5A5958, 64'd3);
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b0);
		// A held prefix is flushed unchanged at the end of the line.
		send_byte(8'h61, 1'b1);
		write_setting(CFG_REPLACEMENT_LENGTH, 64'd0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b1);
	endtask

	// Oversized lengths clamp to eight bytes on both sides.
	task automatic test_length_limits();
		set_rule('1, 64'hF, {$urandom, $urandom}, 64'hF);
		for (int i = 0; i < PATTERN_MAX; i++)
			send_byte(8'hFF, 1'b0);
	endtask

	// Rewriting the pattern length drops the held byte without output.
	task automatic test_held_discard();
		set_rule(64'h6261, 64'd2, 64'h58, 64'd1);
		send_byte(8'h61, 1'b0);
		write_setting(CFG_PATTERN_LENGTH, 64'd2);
		send_byte(8'h62, 1'b1);
	endtask

	// The receiver holds off while the sender keeps offering expanding bytes.
	task automatic test_backpressure();
		set_rule(64'h61, 64'd1, {$urandom, $urandom}, 64'd8);
		sender_calm = 1'b1;
		hold_requests++;
		for (int i = 0; i < 30; i++)
			send_byte(($urandom_range(0, 1) == 0) ? 8'h61 : pick_text_byte(), pick_line_end());
		sender_calm = 1'b0;
		drain_results();
	endtask

	task automatic test_random_text();
		for (int phase = 0; phase < 12; phase++) begin
			set_rule(random_pattern_word(), random_length_word(), {$urandom, $urandom},
				random_length_word());
			sender_calm = (phase % 4 == 3);
			send_mixed_text(40);
		end
		sender_calm = 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pass_through();
		test_match_and_flush();
		test_length_limits();
		test_held_discard();
		test_backpressure();
		test_random_text();
		drain_results();
		repeat (20) @(posedge clk);
		if (pending_text.size() != 0) begin
			$error("%0d expected result transactions never arrived", pending_text.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
